// ===== hdl/mf8e_pkg.sv =====
// ============================================================================
// mf8e_pkg
// Shared types, constants and width helpers for the minifloat8 sample encoder.
// ============================================================================
package mf8e_pkg;

    localparam int SAMPLE_BITS_DEF = 32;
    localparam int FRAC_BITS_DEF   = 16;
    localparam int CFG_BITS        = 32;
    localparam int MEAN_BITS       = 32;
    localparam int GAIN_BITS       = 24;
    localparam int GAIN_FRAC       = 16;
    localparam int CODE_BITS       = 8;
    localparam int EXP_STEPS       = 7;
    localparam int K_BITS          = 3;
    localparam int Q_BITS          = 5;
    localparam int SAT_LIMIT       = 1984;

    localparam logic [GAIN_BITS-1:0] GAIN_RESET = 24'd65536;
    localparam logic [6:0]           MAX_MAG    = 7'h7F;

    typedef enum logic {
        CFG_MEAN = 1'b0,
        CFG_GAIN = 1'b1
    } t_cfg_idx;

    typedef struct packed {
        logic valid;
        logic last;
        logic neg;
    } t_side;

    // product width: wide enough for the full product and the range thresholds
    function automatic int p_width(int sb, int fb);
        int a;
        int b;
        a = sb + GAIN_BITS;
        b = fb + GAIN_FRAC + 11;
        return ((a > b) ? a : b) + 1;
    endfunction

endpackage

// ===== hdl/mf8e_diff.sv =====
// ============================================================================
// mf8e_diff
// Mean subtraction and magnitude/sign split, two register stages.
// ============================================================================
module mf8e_diff #(
    parameter int SAMPLE_BITS = mf8e_pkg::SAMPLE_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    input  logic                            i_last,
    input  logic [SAMPLE_BITS-1:0]          i_sample,
    input  logic [mf8e_pkg::MEAN_BITS-1:0]  i_mean,
    output mf8e_pkg::t_side                 o_side,
    output logic [SAMPLE_BITS-1:0]          o_mag
);

    localparam int SB = SAMPLE_BITS;
    localparam int MB = mf8e_pkg::MEAN_BITS;

    logic [SB-1:0]   w_mean;
    logic [SB:0]     n1_d;
    logic [SB:0]     r1_d;
    logic            r1_valid;
    logic            r1_last;
    logic [SB:0]     w_neg_d;
    logic [SB-1:0]   n2_mag;
    mf8e_pkg::t_side n2_side;
    mf8e_pkg::t_side r2_side;
    logic [SB-1:0]   r2_mag;

    generate
        if (SB <= MB) begin : g_mean_trim
            assign w_mean = i_mean[SB-1:0];
        end else begin : g_mean_pad
            assign w_mean = {{(SB-MB){1'b0}}, i_mean};
        end
    endgenerate

    assign n1_d = {i_sample[SB-1], i_sample} - {w_mean[SB-1], w_mean};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else begin
            r1_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r1_d    <= n1_d;
        r1_last <= i_last;
    end

    always_comb begin
        w_neg_d       = (~r1_d) + {{SB{1'b0}}, 1'b1};
        n2_side.valid = r1_valid;
        n2_side.last  = r1_last;
        n2_side.neg   = r1_d[SB];
        n2_mag        = r1_d[SB] ? w_neg_d[SB-1:0] : r1_d[SB-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_side <= '0;
        end else begin
            r2_side <= n2_side;
        end
    end

    always_ff @(posedge i_clk) begin
        r2_mag <= n2_mag;
    end

    assign o_side = r2_side;
    assign o_mag  = r2_mag;

endmodule

// ===== hdl/mf8e_mult.sv =====
// ============================================================================
// mf8e_mult
// Exact magnitude times gain: split partial products, then sum, two stages.
// ============================================================================
module mf8e_mult #(
    parameter int SAMPLE_BITS = mf8e_pkg::SAMPLE_BITS_DEF,
    parameter int FRAC_BITS   = mf8e_pkg::FRAC_BITS_DEF
) (
    input  logic                                          i_clk,
    input  logic                                          i_rst_n,
    input  mf8e_pkg::t_side                               i_side,
    input  logic [SAMPLE_BITS-1:0]                        i_mag,
    input  logic [mf8e_pkg::GAIN_BITS-1:0]                i_gain,
    output mf8e_pkg::t_side                               o_side,
    output logic [mf8e_pkg::p_width(SAMPLE_BITS, FRAC_BITS)-1:0] o_p
);

    localparam int SB = SAMPLE_BITS;
    localparam int GB = mf8e_pkg::GAIN_BITS;
    localparam int PW = mf8e_pkg::p_width(SAMPLE_BITS, FRAC_BITS);
    localparam int H  = (SAMPLE_BITS + 1) / 2;
    localparam int LW = SAMPLE_BITS - H;

    logic [H+GB-1:0]  r3_pl;
    logic [LW+GB-1:0] r3_ph;
    mf8e_pkg::t_side  r3_side;
    logic [SB+GB-1:0] w_sum;
    logic [PW-1:0]    r4_p;
    mf8e_pkg::t_side  r4_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_side <= '0;
            r4_side <= '0;
        end else begin
            r3_side <= i_side;
            r4_side <= r3_side;
        end
    end

    always_ff @(posedge i_clk) begin
        r3_pl <= i_mag[H-1:0] * i_gain;
        r3_ph <= i_mag[SB-1:H] * i_gain;
    end

    assign w_sum = {r3_ph, {H{1'b0}}} + {{LW{1'b0}}, r3_pl};

    always_ff @(posedge i_clk) begin
        r4_p <= {{(PW-SB-GB){1'b0}}, w_sum};
    end

    assign o_side = r4_side;
    assign o_p    = r4_p;

endmodule

// ===== hdl/mf8e_round.sv =====
// ============================================================================
// mf8e_round
// Range search, saturation and round-to-nearest-even minifloat packing,
// two register stages.
// ============================================================================
module mf8e_round #(
    parameter int SAMPLE_BITS = mf8e_pkg::SAMPLE_BITS_DEF,
    parameter int FRAC_BITS   = mf8e_pkg::FRAC_BITS_DEF
) (
    input  logic                                          i_clk,
    input  logic                                          i_rst_n,
    input  mf8e_pkg::t_side                               i_side,
    input  logic [mf8e_pkg::p_width(SAMPLE_BITS, FRAC_BITS)-1:0] i_p,
    output logic                                          o_valid,
    output logic [mf8e_pkg::CODE_BITS-1:0]                o_code,
    output logic                                          o_saturated,
    output logic                                          o_last
);

    localparam int PW = mf8e_pkg::p_width(SAMPLE_BITS, FRAC_BITS);
    localparam int S  = FRAC_BITS + mf8e_pkg::GAIN_FRAC;
    localparam int NK = mf8e_pkg::EXP_STEPS;
    localparam int KB = mf8e_pkg::K_BITS;
    localparam int QB = mf8e_pkg::Q_BITS;

    logic [NK-1:0]   w_ge63;
    logic [NK:0]     w_gt31;
    logic [KB-1:0]   n5_k;
    logic            n5_big;
    logic            n5_sat;
    logic [KB-1:0]   r5_k;
    logic            r5_big;
    logic            r5_sat;
    logic            r5_nz;
    logic [PW-1:0]   r5_p;
    mf8e_pkg::t_side r5_side;

    logic [QB-1:0]   w_q;
    logic            w_g;
    logic            w_st;
    logic            w_up;
    logic [QB:0]     w_m;
    logic [3:0]      w_e;
    logic [3:0]      w_mant;
    logic [mf8e_pkg::CODE_BITS-1:0] n6_code;
    logic [mf8e_pkg::CODE_BITS-1:0] r6_code;
    logic            r6_sat;
    mf8e_pkg::t_side r6_side;

    always_comb begin
        n5_k = '0;
        for (int kk = 0; kk < NK; kk++) begin
            w_ge63[kk] = i_p >= (PW'(63) << (S - 1 + kk));
        end
        for (int kk = 0; kk <= NK; kk++) begin
            w_gt31[kk] = i_p > (PW'(31) << (S - 1 + kk));
        end
        for (int kk = 0; kk < NK; kk++) begin
            if (w_ge63[kk]) begin
                n5_k = KB'(kk + 1);
            end
        end
        n5_big = w_gt31[n5_k];
        n5_sat = i_p > (PW'(mf8e_pkg::SAT_LIMIT) << S);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_side <= '0;
            r6_side <= '0;
        end else begin
            r5_side <= i_side;
            r6_side <= r5_side;
        end
    end

    always_ff @(posedge i_clk) begin
        r5_k   <= n5_k;
        r5_big <= n5_big;
        r5_sat <= n5_sat;
        r5_nz  <= |i_p;
        r5_p   <= i_p;
    end

    always_comb begin
        w_q  = '0;
        w_g  = 1'b0;
        w_st = 1'b0;
        for (int kk = 0; kk <= NK; kk++) begin
            if (r5_k == KB'(kk)) begin
                w_q  = r5_p[S + kk +: QB];
                w_g  = r5_p[S + kk - 1];
                w_st = |(r5_p & ((PW'(1) << (S + kk - 1)) - PW'(1)));
            end
        end
        w_up = w_g & (w_st | w_q[0]);
        w_m  = {1'b0, w_q} + {{QB{1'b0}}, w_up};
        priority if (r5_big) begin
            w_e    = {1'b0, r5_k} + 4'd1;
            w_mant = w_m[3:0];
        end else if (w_m >= 6'd16) begin
            w_e    = {1'b0, r5_k} + 4'd1;
            w_mant = 4'd0;
        end else begin
            w_e    = {1'b0, r5_k};
            w_mant = w_m[3:0];
        end
        if (w_e > 4'd7) begin
            w_e    = 4'd7;
            w_mant = 4'hF;
        end
        n6_code[6:0] = r5_sat ? mf8e_pkg::MAX_MAG : {w_e[2:0], w_mant};
        n6_code[7]   = r5_side.neg & r5_nz;
    end

    always_ff @(posedge i_clk) begin
        r6_code <= n6_code;
        r6_sat  <= r5_sat;
    end

    assign o_valid     = r6_side.valid;
    assign o_code      = r6_code;
    assign o_saturated = r6_sat;
    assign o_last      = r6_side.last;

endmodule

// ===== hdl/minifloat8_sample_encoder.sv =====
// ============================================================================
// minifloat8_sample_encoder
// Subtracts a mean, scales by a gain and packs each sample as a 1/3/4
// minifloat byte.
// ============================================================================
// One item may start in every cycle, and its result appears on o_strobe once it
// has passed through every register stage of the pipeline, in this order:
// subtract, magnitude, partial products, sum, range compare and round each
// take one register stage. busy stays low, and the result is shown for one
// cycle only, so the receiver must take every item as it comes. Write the
// mean and gain registers only while no item is in flight.
// ============================================================================
module minifloat8_sample_encoder #(
    parameter int SAMPLE_BITS = mf8e_pkg::SAMPLE_BITS_DEF,
    parameter int FRAC_BITS   = mf8e_pkg::FRAC_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [SAMPLE_BITS-1:0]              i_sample,
    input  logic                                i_last_in,
    output logic                                o_strobe,
    output logic [mf8e_pkg::CODE_BITS-1:0]      o_code,
    output logic                                o_saturated,
    output logic                                o_last_out,
    input  logic                                i_cfg_we,
    input  logic [0:0]                          i_cfg_idx,
    input  logic [mf8e_pkg::CFG_BITS-1:0]       i_cfg_data
);

    localparam int PW = mf8e_pkg::p_width(SAMPLE_BITS, FRAC_BITS);

    logic [mf8e_pkg::MEAN_BITS-1:0] r_mean;
    logic [mf8e_pkg::GAIN_BITS-1:0] r_gain;
    logic                           w_accept;
    mf8e_pkg::t_side                w_diff_side;
    logic [SAMPLE_BITS-1:0]         w_mag;
    mf8e_pkg::t_side                w_mult_side;
    logic [PW-1:0]                  w_p;

    assign busy     = 1'b0;
    assign w_accept = start & ~busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mean <= '0;
            r_gain <= mf8e_pkg::GAIN_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                mf8e_pkg::CFG_MEAN: r_mean <= i_cfg_data[mf8e_pkg::MEAN_BITS-1:0];
                mf8e_pkg::CFG_GAIN: r_gain <= i_cfg_data[mf8e_pkg::GAIN_BITS-1:0];
                default:            r_gain <= r_gain;
            endcase
        end
    end

    mf8e_diff #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_diff (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (w_accept),
        .i_last   (i_last_in),
        .i_sample (i_sample),
        .i_mean   (r_mean),
        .o_side   (w_diff_side),
        .o_mag    (w_mag)
    );

    mf8e_mult #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .FRAC_BITS   (FRAC_BITS)
    ) u_mult (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_side  (w_diff_side),
        .i_mag   (w_mag),
        .i_gain  (r_gain),
        .o_side  (w_mult_side),
        .o_p     (w_p)
    );

    mf8e_round #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .FRAC_BITS   (FRAC_BITS)
    ) u_round (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_side      (w_mult_side),
        .i_p         (w_p),
        .o_valid     (o_strobe),
        .o_code      (o_code),
        .o_saturated (o_saturated),
        .o_last      (o_last_out)
    );

    a_strobe_follows_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |-> ##6 o_strobe)
        else $error("item accepted but no result six cycles later");

    a_no_spurious_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_accept |-> ##6 !o_strobe)
        else $error("result strobe without an accepted item");

    a_last_carried: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |-> ##6 (o_last_out == $past(i_last_in, 6)))
        else $error("last flag not carried with its item");

    a_sat_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_saturated) |-> (o_code[6:0] == mf8e_pkg::MAX_MAG))
        else $error("saturated result without the largest magnitude code");

endmodule
